// ===== sv/lat_pkg.sv =====
// ----------------------------------------------------------------------------
// lat_pkg
// Shared request codes, heading codes and default sizes for the ant grid.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  localparam int GRID_SIZE_DEF = 256;
  localparam int NUM_ANTS_DEF  = 4;

  typedef enum logic [1:0] {
    REQ_STEP  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PLACE = 2'd2
  } req_t;

  localparam logic [1:0] HEAD_UP    = 2'd0;
  localparam logic [1:0] HEAD_RIGHT = 2'd1;
  localparam logic [1:0] HEAD_DOWN  = 2'd2;
  localparam logic [1:0] HEAD_LEFT  = 2'd3;

  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd3;
  localparam logic [1:0] TURN_BACK  = 2'd2;

endpackage

`default_nettype wire

// ===== sv/lat_grid_mem.sv =====
// ----------------------------------------------------------------------------
// lat_grid_mem
// Grid store, one row of cells per entry, bit write, registered row read,
// and a row-by-row clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_grid_mem #(
  parameter int GRID_SIZE = 256,
  parameter int CW        = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  output logic                      busy,
  input  wire logic                 rd_en,
  input  wire logic [CW-1:0]        rd_row,
  output logic [GRID_SIZE-1:0]      rd_data,
  input  wire logic                 wr_en,
  input  wire logic [CW-1:0]        wr_row,
  input  wire logic [CW-1:0]        wr_col,
  input  wire logic                 wr_bit
);

  localparam logic [CW-1:0] LAST_ROW = CW'(GRID_SIZE - 1);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] rd_q;
  logic                 clr_active;
  logic [CW-1:0]        clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      if (clr_row == LAST_ROW) begin
        clr_active <= 1'b0;
      end
      clr_row <= clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_row] <= '0;
    end else if (wr_en) begin
      mem[wr_row][wr_col] <= wr_bit;
    end
    if (rd_en) begin
      rd_q <= mem[rd_row];
    end
  end

  assign busy    = clr_active;
  assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== sv/lat_ant_move.sv =====
// ----------------------------------------------------------------------------
// lat_ant_move
// Turn on the cell value, advance one cell, reverse at the border.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_ant_move #(
  parameter int GRID_SIZE = 256,
  parameter int CW        = 8
) (
  input  wire logic [CW-1:0] col,
  input  wire logic [CW-1:0] row,
  input  wire logic [1:0]    heading,
  input  wire logic          cell_bit,
  output logic [CW-1:0]      col_next,
  output logic [CW-1:0]      row_next,
  output logic [1:0]         heading_next,
  output logic               bounce
);

  import lat_pkg::*;

  localparam logic [CW-1:0] MAX_POS = CW'(GRID_SIZE - 1);

  function automatic logic can_go(logic [CW-1:0] c, logic [CW-1:0] r, logic [1:0] h);
    logic ok;
    case (h)
      HEAD_UP:    ok = (r != '0);
      HEAD_RIGHT: ok = (c != MAX_POS);
      HEAD_DOWN:  ok = (r != MAX_POS);
      default:    ok = (c != '0);
    endcase
    return ok;
  endfunction

  function automatic logic [CW-1:0] col_after(logic [CW-1:0] c, logic [1:0] h);
    logic [CW-1:0] v;
    case (h)
      HEAD_RIGHT: v = c + 1'b1;
      HEAD_LEFT:  v = c - 1'b1;
      default:    v = c;
    endcase
    return v;
  endfunction

  function automatic logic [CW-1:0] row_after(logic [CW-1:0] r, logic [1:0] h);
    logic [CW-1:0] v;
    case (h)
      HEAD_UP:   v = r - 1'b1;
      HEAD_DOWN: v = r + 1'b1;
      default:   v = r;
    endcase
    return v;
  endfunction

  logic [1:0] h_turn;
  logic [1:0] h_back;
  logic       ok_turn;
  logic       ok_back;

  always_comb begin
    h_turn  = heading + (cell_bit ? TURN_LEFT : TURN_RIGHT);
    h_back  = h_turn + TURN_BACK;
    ok_turn = can_go(col, row, h_turn);
    ok_back = can_go(col, row, h_back);
    bounce  = !ok_turn;
    if (ok_turn) begin
      heading_next = h_turn;
      col_next     = col_after(col, h_turn);
      row_next     = row_after(row, h_turn);
    end else if (ok_back) begin
      heading_next = h_back;
      col_next     = col_after(col, h_back);
      row_next     = row_after(row, h_back);
    end else begin
      heading_next = h_back;
      col_next     = col;
      row_next     = row;
    end
  end

endmodule

`default_nettype wire

// ===== sv/langton_ant_grid_step.sv =====
// ----------------------------------------------------------------------------
// langton_ant_grid_step
// Several ants stepping on a shared one-bit grid, with place and read requests.
//
// Input channel (in_valid/in_ready) carries one request per transaction; the
// output channel (out_valid/out_ready) returns exactly one result for each,
// in request order. A result is offered from the output register after its
// request has passed the update stage. Requests issue one per cycle unless
// the update stage is held or the grid is clearing; a request other than a
// place that names the ant of a step or place still in the update stage waits
// for it, as the grid read-modify-write and the ant register update happen there.
// The grid row memory has one read port and one bit-write port; a read of a
// cell written in the same cycle is forwarded.
// After reset the grid is cleared one row per cycle, every row in turn, and
// in_ready stays low meanwhile. Ants reset to the origin heading up.
// A stalled receiver holds the output register; one further request is
// still taken and held in the update stage until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module langton_ant_grid_step #(
  parameter int GRID_SIZE = lat_pkg::GRID_SIZE_DEF,
  parameter int NUM_ANTS  = lat_pkg::NUM_ANTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [1:0] ant_select,
  input  wire logic [7:0] pos_x,
  input  wire logic [7:0] pos_y,
  input  wire logic [1:0] heading_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      ant_x,
  output logic [7:0]      ant_y,
  output logic [1:0]      ant_heading,
  output logic            cell_value,
  output logic            bounced
);

  import lat_pkg::*;

  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = (NUM_ANTS > 1) ? $clog2(NUM_ANTS) : 1;
  localparam logic [15:0]   GRID_LIM = 16'(GRID_SIZE);
  localparam logic [4:0]    ANT_LIM  = 5'(NUM_ANTS);
  localparam logic [CW-1:0] MAX_POS  = CW'(GRID_SIZE - 1);

  logic [NUM_ANTS-1:0][CW-1:0] ant_col_q;
  logic [NUM_ANTS-1:0][CW-1:0] ant_row_q;
  logic [NUM_ANTS-1:0][1:0]    ant_dir_q;

  logic                 b_valid;
  logic [1:0]           b_req;
  logic [1:0]           b_sel;
  logic [AW-1:0]        b_idx;
  logic                 b_ok;
  logic [CW-1:0]        b_ant_col;
  logic [CW-1:0]        b_ant_row;
  logic [1:0]           b_ant_h;
  logic [CW-1:0]        b_row;
  logic [CW-1:0]        b_col;
  logic [7:0]           b_px;
  logic [7:0]           b_py;
  logic                 b_x_in;
  logic                 b_y_in;
  logic [1:0]           b_hin;
  logic                 b_fwd;
  logic                 b_fwd_bit;

  logic                 grid_busy;
  logic [GRID_SIZE-1:0] rd_data;
  logic                 accept;
  logic                 b_fire;
  logic                 b_mod;
  logic                 hazard;
  logic [AW-1:0]        a_idx;
  logic                 a_ok;
  logic [CW-1:0]        a_row;
  logic [CW-1:0]        a_col;
  logic                 a_x_in;
  logic                 a_y_in;

  logic                 cell_raw;
  logic                 cell_cur;
  logic                 wr_en;
  logic                 ant_upd;
  logic [CW-1:0]        new_col;
  logic [CW-1:0]        new_row;
  logic [1:0]           new_h;
  logic                 bounce;
  logic [CW-1:0]        mv_col;
  logic [CW-1:0]        mv_row;
  logic [1:0]           mv_h;
  logic                 mv_bounce;

  // Issue stage
  always_comb begin
    a_idx  = AW'(ant_select);
    a_ok   = ({3'b000, ant_select} < ANT_LIM);
    a_x_in = (16'(pos_x) < GRID_LIM);
    a_y_in = (16'(pos_y) < GRID_LIM);
    if (req_type == REQ_STEP) begin
      a_row = ant_row_q[a_idx];
      a_col = ant_col_q[a_idx];
    end else begin
      a_row = CW'(pos_y);
      a_col = CW'(pos_x);
    end
    b_mod    = b_valid && b_ok && (b_req == REQ_STEP || b_req == REQ_PLACE);
    hazard   = b_mod && (b_sel == ant_select) && (req_type != REQ_PLACE);
    b_fire   = b_valid && (!out_valid || out_ready);
    in_ready = !grid_busy && (!b_valid || b_fire) && !hazard;
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_req     <= req_type;
      b_sel     <= ant_select;
      b_idx     <= a_idx;
      b_ok      <= a_ok;
      b_ant_col <= ant_col_q[a_idx];
      b_ant_row <= ant_row_q[a_idx];
      b_ant_h   <= ant_dir_q[a_idx];
      b_row     <= a_row;
      b_col     <= a_col;
      b_px      <= pos_x;
      b_py      <= pos_y;
      b_x_in    <= a_x_in;
      b_y_in    <= a_y_in;
      b_hin     <= heading_in;
      b_fwd     <= wr_en && (a_row == b_row) && (a_col == b_col);
      b_fwd_bit <= !cell_cur;
    end
  end

  lat_grid_mem #(
    .GRID_SIZE (GRID_SIZE),
    .CW        (CW)
  ) u_grid (
    .clk     (clk),
    .rst     (rst),
    .busy    (grid_busy),
    .rd_en   (accept),
    .rd_row  (a_row),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_row  (b_row),
    .wr_col  (b_col),
    .wr_bit  (!cell_cur)
  );

  lat_ant_move #(
    .GRID_SIZE (GRID_SIZE),
    .CW        (CW)
  ) u_move (
    .col          (b_ant_col),
    .row          (b_ant_row),
    .heading      (b_ant_h),
    .cell_bit     (cell_raw),
    .col_next     (mv_col),
    .row_next     (mv_row),
    .heading_next (mv_h),
    .bounce       (mv_bounce)
  );

  // Update stage
  always_comb begin
    cell_raw = b_fwd ? b_fwd_bit : rd_data[b_col];
    cell_cur = 1'b0;
    bounce   = 1'b0;
    wr_en    = 1'b0;
    ant_upd  = 1'b0;
    new_col  = b_ant_col;
    new_row  = b_ant_row;
    new_h    = b_ant_h;
    case (b_req)
      REQ_STEP: begin
        if (b_ok) begin
          cell_cur = cell_raw;
          bounce   = mv_bounce;
          wr_en    = b_fire;
          ant_upd  = 1'b1;
          new_col  = mv_col;
          new_row  = mv_row;
          new_h    = mv_h;
        end
      end
      REQ_READ: begin
        cell_cur = b_x_in && b_y_in && cell_raw;
      end
      REQ_PLACE: begin
        if (b_ok) begin
          ant_upd = 1'b1;
          new_col = b_x_in ? CW'(b_px) : MAX_POS;
          new_row = b_y_in ? CW'(b_py) : MAX_POS;
          new_h   = b_hin;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ant_col_q <= '0;
      ant_row_q <= '0;
      ant_dir_q <= '0;
    end else if (b_fire && ant_upd) begin
      ant_col_q[b_idx] <= new_col;
      ant_row_q[b_idx] <= new_row;
      ant_dir_q[b_idx] <= new_h;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      ant_x       <= b_ok ? 8'(new_col) : 8'd0;
      ant_y       <= b_ok ? 8'(new_row) : 8'd0;
      ant_heading <= b_ok ? new_h : 2'd0;
      cell_value  <= cell_cur;
      bounced     <= bounce;
    end
  end

`ifndef ASSERT_OFF
  a_clear_idle : assert property (@(posedge clk) disable iff (rst)
    grid_busy |-> !b_valid && !wr_en)
    else $error("update stage active during grid clearing pass");

  a_result_out : assert property (@(posedge clk) disable iff (rst)
    b_fire |=> out_valid)
    else $error("completed transaction produced no result");

  a_ants_hold : assert property (@(posedge clk) disable iff (rst)
    !(b_fire && ant_upd) |=> $stable(ant_col_q) && $stable(ant_row_q) && $stable(ant_dir_q))
    else $error("ant state changed without an update");

  a_step_flip : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> b_req == REQ_STEP && b_ok && b_fire)
    else $error("grid written outside a completing step");
`endif

endmodule

`default_nettype wire

// ===== tb/langton_ant_grid_step_tb.sv =====
// ----------------------------------------------------------------------------
// langton_ant_grid_step_tb
// Drives step, read, place and unknown requests into the ant grid block and
// compares every result against an independent model of the grid and ants.
// Covers border bounces, ants sharing one cell, random walks after placement,
// bursty input, an irregular receiver and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module langton_ant_grid_step_tb;
  import lat_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [7:0] EDGE_POS    = 8'(GRID_SIZE_DEF - 1);
  localparam int         TOTAL_REQS  = 1275;
  localparam int         LIMIT_CYC   = 400000;
  localparam int         HOLD_CYC    = 400;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] heading;
    logic       cell_bit;
    logic       bounce;
  } ant_result_t;

  class ant_grid_scoreboard;
    bit          cells [GRID_SIZE_DEF * GRID_SIZE_DEF];
    logic [7:0]  pos_col [NUM_ANTS_DEF];
    logic [7:0]  pos_row [NUM_ANTS_DEF];
    logic [1:0]  facing [NUM_ANTS_DEF];
    ant_result_t pending_results [$];
    int errors, requests, results, steps, bounces, reads, places, unknowns;

    function new();
      foreach (cells[i]) cells[i] = 1'b0;
      foreach (pos_col[i]) begin
        pos_col[i] = '0;
        pos_row[i] = '0;
        facing[i]  = HEAD_UP;
      end
    endfunction

    function bit next_cell(input logic [7:0] c, input logic [7:0] r, input logic [1:0] hd,
                           output logic [7:0] nc, output logic [7:0] nr);
      nc = c;
      nr = r;
      case (hd)
        HEAD_UP: begin
          if (r == 8'd0) return 1'b0;
          nr = r - 8'd1;
        end
        HEAD_RIGHT: begin
          if (c == EDGE_POS) return 1'b0;
          nc = c + 8'd1;
        end
        HEAD_DOWN: begin
          if (r == EDGE_POS) return 1'b0;
          nr = r + 8'd1;
        end
        default: begin
          if (c == 8'd0) return 1'b0;
          nc = c - 8'd1;
        end
      endcase
      return 1'b1;
    endfunction

    function void take_request(logic [1:0] kind, logic [1:0] sel, logic [7:0] px,
                               logic [7:0] py, logic [1:0] hin);
      ant_result_t res;
      logic [15:0] idx;
      logic [1:0]  hd;
      logic [7:0]  nc, nr;
      res = '0;
      requests++;
      case (kind)
        REQ_STEP: begin
          steps++;
          idx = {pos_row[sel], pos_col[sel]};
          res.cell_bit = cells[idx];
          cells[idx] = !res.cell_bit;
          hd = facing[sel] + (res.cell_bit ? TURN_LEFT : TURN_RIGHT);
          if (!next_cell(pos_col[sel], pos_row[sel], hd, nc, nr)) begin
            res.bounce = 1'b1;
            bounces++;
            hd = hd + TURN_BACK;
            if (!next_cell(pos_col[sel], pos_row[sel], hd, nc, nr)) begin
              nc = pos_col[sel];
              nr = pos_row[sel];
            end
          end
          pos_col[sel] = nc;
          pos_row[sel] = nr;
          facing[sel]  = hd;
        end
        REQ_READ: begin
          reads++;
          res.cell_bit = cells[{py, px}];
        end
        REQ_PLACE: begin
          places++;
          pos_col[sel] = px;
          pos_row[sel] = py;
          facing[sel]  = hin;
        end
        default: unknowns++;
      endcase
      res.x       = pos_col[sel];
      res.y       = pos_row[sel];
      res.heading = facing[sel];
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      if (errors < 40)
        $display("mismatch on result %0d: %s got %0h, want %0h", results, what, got, want);
      errors++;
    endtask

    task check_result(logic [7:0] x, logic [7:0] y, logic [1:0] hd, logic cv, logic bn);
      ant_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding", 8'(x), 8'd0);
      end else begin
        want = pending_results.pop_front();
        if (x !== want.x) report("ant_x", x, want.x);
        if (y !== want.y) report("ant_y", y, want.y);
        if (hd !== want.heading) report("ant_heading", 8'(hd), 8'(want.heading));
        if (cv !== want.cell_bit) report("cell_value", 8'(cv), 8'(want.cell_bit));
        if (bn !== want.bounce) report("bounced", 8'(bn), 8'(want.bounce));
      end
      results++;
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] req_type = REQ_READ;
  logic [1:0] ant_select = '0;
  logic [7:0] pos_x = '0;
  logic [7:0] pos_y = '0;
  logic [1:0] heading_in = HEAD_UP;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] ant_x;
  logic [7:0] ant_y;
  logic [1:0] ant_heading;
  logic       cell_value;
  logic       bounced;

  ant_grid_scoreboard sb = new();
  int burst_left = 0;
  int sent = 0;

  langton_ant_grid_step dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .ant_select (ant_select),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .heading_in (heading_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ant_x      (ant_x),
    .ant_y      (ant_y),
    .ant_heading(ant_heading),
    .cell_value (cell_value),
    .bounced    (bounced)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYC * 10);
    $display("langton_ant_grid_step_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.take_request(req_type, ant_select, pos_x, pos_y, heading_in);
      if (out_valid && out_ready)
        sb.check_result(ant_x, ant_y, ant_heading, cell_value, bounced);
    end
  end

  // receiver: changing stall pattern, plus one long hold-off mid-run
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && sb.requests >= 500) begin
        held = 1'b1;
        hold_left = HOLD_CYC;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  task automatic send(logic [1:0] kind, logic [1:0] sel, logic [7:0] px, logic [7:0] py,
                      logic [1:0] hin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= kind;
    ant_select <= sel;
    pos_x      <= px;
    pos_y      <= py;
    heading_in <= hin;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [7:0] coord_pick();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return EDGE_POS;
      2: return $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] near(logic [7:0] v);
    return v + 8'($urandom_range(0, 2)) - 8'd1;
  endfunction

  initial begin
    int focus;
    int other;
    int pick;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(REQ_READ, 2'd0, 8'd0, 8'd0, HEAD_UP);
    send(REQ_READ, 2'd3, EDGE_POS, EDGE_POS, HEAD_LEFT);
    send(REQ_STEP, 2'd0, 8'd0, 8'd0, HEAD_UP);
    send(REQ_STEP, 2'd0, 8'hAA, 8'h55, HEAD_DOWN);
    send(REQ_READ, 2'd0, 8'd0, 8'd0, HEAD_UP);
    send(REQ_PLACE, 2'd1, 8'd0, EDGE_POS, HEAD_DOWN);
    send(REQ_STEP, 2'd1, 8'd0, 8'd0, HEAD_UP);
    send(REQ_PLACE, 2'd2, EDGE_POS, 8'd0, HEAD_UP);
    send(REQ_STEP, 2'd2, 8'd0, 8'd0, HEAD_UP);
    send(REQ_PLACE, 2'd3, EDGE_POS, EDGE_POS, HEAD_RIGHT);
    send(REQ_STEP, 2'd3, EDGE_POS, EDGE_POS, HEAD_LEFT);
    send(REQ_PLACE, 2'd3, 8'd0, 8'd0, HEAD_UP);
    send(REQ_STEP, 2'd3, 8'd0, 8'd0, HEAD_UP);
    send(REQ_PLACE, 2'd0, 8'd128, 8'd128, HEAD_UP);
    send(REQ_PLACE, 2'd1, 8'd128, 8'd128, HEAD_UP);
    send(REQ_STEP, 2'd0, 8'd0, 8'd0, HEAD_UP);
    send(REQ_STEP, 2'd1, 8'd0, 8'd0, HEAD_UP);
    send(REQ_STEP, 2'd0, 8'd0, 8'd0, HEAD_UP);
    send(REQ_STEP, 2'd0, 8'd0, 8'd0, HEAD_UP);
    send(REQ_READ, 2'd1, 8'd128, 8'd128, HEAD_UP);
    send(REQ_READ, 2'd2, 8'd129, 8'd128, HEAD_UP);
    send(REQ_UNKNOWN, 2'd2, 8'h5A, 8'hA5, HEAD_RIGHT);
    send(REQ_UNKNOWN, 2'd3, EDGE_POS, EDGE_POS, HEAD_LEFT);

    while (sent < TOTAL_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        focus = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) begin
          other = $urandom_range(0, 3);
          if ($urandom_range(0, 4) == 0)
            send(REQ_PLACE, 2'(focus), sb.pos_col[other], sb.pos_row[other],
                 2'($urandom_range(0, 3)));
          else
            send(REQ_PLACE, 2'(focus), coord_pick(), coord_pick(), 2'($urandom_range(0, 3)));
        end
        k = $urandom_range(4, 40);
        repeat (k) begin
          pick = $urandom_range(0, 99);
          if (pick < 78)
            send(REQ_STEP, 2'(focus), 8'($urandom), 8'($urandom), 2'($urandom));
          else if (pick < 88)
            send(REQ_STEP, 2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
          else
            send(REQ_READ, 2'(focus), near(sb.pos_col[focus]), near(sb.pos_row[focus]),
                 2'($urandom));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: send(REQ_READ, 2'($urandom), coord_pick(), coord_pick(), 2'($urandom));
          1: send(REQ_PLACE, 2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
          2: send(REQ_UNKNOWN, 2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
          default: send(REQ_STEP, 2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
        endcase
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests: %0d steps (%0d bounces), %0d reads, %0d places, %0d unknown",
             sb.requests, sb.steps, sb.bounces, sb.reads, sb.places, sb.unknowns);
    $display("checked %0d results, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("langton_ant_grid_step_tb: done, clean");
    end else begin
      $display("langton_ant_grid_step_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/lat_pkg.sv
sv/lat_grid_mem.sv
sv/lat_ant_move.sv
sv/langton_ant_grid_step.sv
tb/langton_ant_grid_step_tb.sv
